### design/bgd_pkg.sv
package bgd_pkg;

    localparam int TIME_BITS = 16;
    localparam int LIMIT_BITS = 16;
    localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;
    localparam int DEB_BITS = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_DOUBLE_TAP = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam logic [DEB_BITS-1:0]   DEBOUNCE_RESET   = 8'd30;
    localparam logic [LIMIT_BITS-1:0] LONG_PRESS_RESET = 16'd5000;
    localparam logic [LIMIT_BITS-1:0] DOUBLE_TAP_RESET = 16'd300;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DEB1   = 3'd1,
        ST_PRESS1 = 3'd2,
        ST_WAIT   = 3'd3,
        ST_DEB2   = 3'd4,
        ST_PRESS2 = 3'd5
    } state_t;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_SINGLE_TAP = 2'd1,
        EV_DOUBLE_TAP = 2'd2,
        EV_LONG_PRESS = 2'd3
    } event_t;

    localparam logic [23:0] COL_GREEN   = 24'h00FF00;
    localparam logic [23:0] COL_STANDBY = 24'h00001E;
    localparam logic [23:0] COL_WHITE   = 24'hFFFFFF;
    localparam logic [23:0] COL_MAGENTA = 24'hFF00FF;
    localparam logic [23:0] COL_BLUE    = 24'h0000FF;

endpackage

### design/button_gesture_detector.sv
// Button gesture detector. Each input item is one millisecond tick carrying the sampled
// button level in s_tdata bit 0; each tick yields exactly one output item with the gesture
// event (none, single tap, double tap, long press) and the inverted red, green and blue LED
// duties. A press is confirmed after debounce_ms ticks with a recheck of the level on the
// last tick of the wait; a long press fires once while the first press is held for
// long_press_ms ticks; a single tap fires when double_tap_ms ticks pass after the first
// release with no confirmed second press, unless a long press fired. Every item passes
// through the input register, then the state update into the output register, and one
// item is taken every cycle while the output side keeps up. Configuration writes on cfg_we
// apply at once and should only be made while no ticks are in flight.
module button_gesture_detector
    import bgd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] button_down, [7:1] zero
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [1:0] gesture_event, [9:2] red_duty,
                                                 // [17:10] green_duty, [25:18] blue_duty,
                                                 // [31:26] zero
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [DEB_BITS-1:0]   debounce_ms_reg;
    logic [LIMIT_BITS-1:0] long_press_ms_reg;
    logic [LIMIT_BITS-1:0] double_tap_ms_reg;

    logic in_valid_reg;
    logic in_down_reg;

    state_t                state_reg, state_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next, elapsed_inc;
    logic [DEB_BITS-1:0]   deb_count_reg, deb_count_next, deb_inc;
    logic                  long_fired_reg, long_fired_next;
    logic [23:0]           colour_reg, colour_next;
    event_t                event_comb;

    logic                  out_valid_reg;
    event_t                out_event_reg;
    logic [7:0]            red_duty_reg, green_duty_reg, blue_duty_reg;

    logic advance;
    logic deb_done;
    logic long_hit;
    logic tap_expired;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= DEBOUNCE_RESET;
            long_press_ms_reg <= LONG_PRESS_RESET;
            double_tap_ms_reg <= DOUBLE_TAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:   debounce_ms_reg   <= cfg_data[DEB_BITS-1:0];
                CFG_LONG_PRESS: long_press_ms_reg <= cfg_data[LIMIT_BITS-1:0];
                CFG_DOUBLE_TAP: double_tap_ms_reg <= cfg_data[LIMIT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_down_reg <= s_tdata[0];
        end
    end

    // shared conditions
    assign elapsed_inc = (state_reg != ST_IDLE && elapsed_reg != '1)
                       ? elapsed_reg + TIME_BITS'(1) : elapsed_reg;
    assign deb_inc     = deb_count_reg + DEB_BITS'(1);
    assign deb_done    = deb_inc >= debounce_ms_reg;
    assign long_hit    = !long_fired_reg
                       && (CMP_BITS'(elapsed_inc) >= CMP_BITS'(long_press_ms_reg));
    assign tap_expired = CMP_BITS'(elapsed_inc) > CMP_BITS'(double_tap_ms_reg);

    // next state
    always_comb
    begin
        state_next      = state_reg;
        elapsed_next    = elapsed_inc;
        deb_count_next  = deb_count_reg;
        long_fired_next = long_fired_reg;
        unique case (state_reg)
            ST_DEB1:
            begin
                deb_count_next = deb_inc;
                if (deb_done)
                begin
                    if (in_down_reg)
                    begin
                        state_next      = ST_PRESS1;
                        long_fired_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PRESS1:
            begin
                if (!in_down_reg)
                begin
                    elapsed_next = '0;
                    state_next   = ST_WAIT;
                end
                else if (long_hit)
                begin
                    long_fired_next = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (in_down_reg)
                begin
                    deb_count_next = '0;
                    state_next     = (debounce_ms_reg == '0) ? ST_PRESS2 : ST_DEB2;
                end
                else if (tap_expired)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEB2:
            begin
                deb_count_next = deb_inc;
                if (deb_done)
                begin
                    state_next = in_down_reg ? ST_PRESS2 : ST_WAIT;
                end
            end
            ST_PRESS2:
            begin
                if (!in_down_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                if (in_down_reg)
                begin
                    elapsed_next   = '0;
                    deb_count_next = '0;
                    if (debounce_ms_reg == '0)
                    begin
                        state_next      = ST_PRESS1;
                        long_fired_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DEB1;
                    end
                end
            end
        endcase
    end

    // event and colour
    always_comb
    begin
        event_comb  = EV_NONE;
        colour_next = colour_reg;
        unique case (state_reg)
            ST_DEB1:
            begin
                if (deb_done && in_down_reg)
                begin
                    colour_next = COL_GREEN;
                end
            end
            ST_PRESS1:
            begin
                if (!in_down_reg)
                begin
                    colour_next = COL_STANDBY;
                end
                else if (long_hit)
                begin
                    event_comb  = EV_LONG_PRESS;
                    colour_next = COL_WHITE;
                end
            end
            ST_WAIT:
            begin
                if (in_down_reg)
                begin
                    if (debounce_ms_reg == '0)
                    begin
                        event_comb  = EV_DOUBLE_TAP;
                        colour_next = COL_MAGENTA;
                    end
                end
                else if (tap_expired && !long_fired_reg)
                begin
                    event_comb = EV_SINGLE_TAP;
                end
            end
            ST_DEB2:
            begin
                if (deb_done && in_down_reg)
                begin
                    event_comb  = EV_DOUBLE_TAP;
                    colour_next = COL_MAGENTA;
                end
            end
            ST_PRESS2:
            begin
                if (!in_down_reg)
                begin
                    colour_next = COL_BLUE;
                end
            end
            default:
            begin
                if (in_down_reg && debounce_ms_reg == '0)
                begin
                    colour_next = COL_GREEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            elapsed_reg    <= '0;
            deb_count_reg  <= '0;
            long_fired_reg <= 1'b0;
            colour_reg     <= COL_STANDBY;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            elapsed_reg    <= elapsed_next;
            deb_count_reg  <= deb_count_next;
            long_fired_reg <= long_fired_next;
            colour_reg     <= colour_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg  <= event_comb;
            red_duty_reg   <= ~colour_next[23:16];
            green_duty_reg <= ~colour_next[15:8];
            blue_duty_reg  <= ~colour_next[7:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, blue_duty_reg, green_duty_reg, red_duty_reg, out_event_reg};

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input side stalled while input register empty");

    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("item lost between input and output register");

    a_long_fire_event: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(long_fired_reg) |-> (m_tvalid && out_event_reg == EV_LONG_PRESS))
        else $error("long press flag set without long press item");

    a_wait_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT || state_reg == ST_DEB2) |-> colour_reg == COL_STANDBY)
        else $error("colour not standby while waiting for second press");

    a_press2_colour: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PRESS2 |-> colour_reg == COL_MAGENTA)
        else $error("colour not magenta while second press held");

endmodule

### tb/tb.sv
module tb;
    import bgd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    typedef struct packed {
        event_t     ev;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tick_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [31:0]               m_tdata;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_DEBOUNCE;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // gesture predictor state and its copy of the timing registers
    state_t                 gest_state;
    logic [TIME_BITS-1:0]   elapsed;
    logic [DEB_BITS-1:0]    deb_count;
    logic                   long_done;
    logic [23:0]            led_rgb;
    logic [DEB_BITS-1:0]    deb_limit;
    logic [LIMIT_BITS-1:0]  long_limit;
    logic [LIMIT_BITS-1:0]  tap_window;

    bit                     pending_levels[$];
    tick_result_t           expected_ticks[$];
    int unsigned            n_queued = 0;
    int unsigned            n_results = 0;
    int unsigned            cycle_count = 0;
    int unsigned            hold_left = 0;
    bit                     hold_done = 1'b0;
    bit                     in_taken = 1'b0;
    bit                     failed = 1'b0;

    button_gesture_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // long quiet stretches with no idling on either side
    function automatic bit take_break();
        if ((cycle_count / 200) % 4 == 1)
            return 1'b0;
        return $urandom_range(99) < 24;
    endfunction

    task automatic advance_gesture(input logic down);
        tick_result_t r;
        event_t       ev;
        ev = EV_NONE;
        if (gest_state > ST_PRESS2)
            gest_state = ST_IDLE;
        if (gest_state != ST_IDLE && elapsed != '1)
            elapsed = elapsed + 1'b1;
        case (gest_state)
            ST_IDLE:
            begin
                if (down)
                begin
                    elapsed = '0;
                    deb_count = '0;
                    if (deb_limit == 0)
                    begin
                        gest_state = ST_PRESS1;
                        long_done = 1'b0;
                        led_rgb = COL_GREEN;
                    end
                    else
                        gest_state = ST_DEB1;
                end
            end
            ST_DEB1:
            begin
                deb_count = deb_count + 1'b1;
                if (deb_count >= deb_limit)
                begin
                    if (down)
                    begin
                        gest_state = ST_PRESS1;
                        long_done = 1'b0;
                        led_rgb = COL_GREEN;
                    end
                    else
                        gest_state = ST_IDLE;
                end
            end
            ST_PRESS1:
            begin
                if (!down)
                begin
                    elapsed = '0;
                    gest_state = ST_WAIT;
                    led_rgb = COL_STANDBY;
                end
                else if (!long_done && elapsed >= long_limit)
                begin
                    long_done = 1'b1;
                    ev = EV_LONG_PRESS;
                    led_rgb = COL_WHITE;
                end
            end
            ST_WAIT:
            begin
                if (down)
                begin
                    deb_count = '0;
                    if (deb_limit == 0)
                    begin
                        gest_state = ST_PRESS2;
                        led_rgb = COL_MAGENTA;
                        ev = EV_DOUBLE_TAP;
                    end
                    else
                        gest_state = ST_DEB2;
                end
                else if (elapsed > tap_window)
                begin
                    if (!long_done)
                        ev = EV_SINGLE_TAP;
                    gest_state = ST_IDLE;
                end
            end
            ST_DEB2:
            begin
                deb_count = deb_count + 1'b1;
                if (deb_count >= deb_limit)
                begin
                    if (down)
                    begin
                        gest_state = ST_PRESS2;
                        led_rgb = COL_MAGENTA;
                        ev = EV_DOUBLE_TAP;
                    end
                    else
                        gest_state = ST_WAIT;
                end
            end
            default:
            begin
                if (!down)
                begin
                    gest_state = ST_IDLE;
                    led_rgb = COL_BLUE;
                end
            end
        endcase
        r.ev = ev;
        r.red = 8'd255 - led_rgb[23:16];
        r.green = 8'd255 - led_rgb[15:8];
        r.blue = 8'd255 - led_rgb[7:0];
        expected_ticks.push_back(r);
    endtask

    // monitor: predict on every accepted tick, then check every accepted result
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                advance_gesture(s_tdata[0]);
            if (m_tvalid && m_tready)
            begin
                n_results <= n_results + 1;
                if (expected_ticks.size() == 0)
                begin
                    $error("result with no tick waiting: %h", m_tdata);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (m_tdata[1:0] !== want.ev)
                    begin
                        $error("gesture_event: expected %0d, actual %0d", want.ev,
                            m_tdata[1:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[9:2] !== want.red)
                    begin
                        $error("red_duty: expected %0d, actual %0d", want.red, m_tdata[9:2]);
                        failed = 1'b1;
                    end
                    if (m_tdata[17:10] !== want.green)
                    begin
                        $error("green_duty: expected %0d, actual %0d", want.green,
                            m_tdata[17:10]);
                        failed = 1'b1;
                    end
                    if (m_tdata[25:18] !== want.blue)
                    begin
                        $error("blue_duty: expected %0d, actual %0d", want.blue,
                            m_tdata[25:18]);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // driver: one tick per item from the pending queue
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_levels.size() > 0 && !take_break())
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, pending_levels.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result side, with one long hold-off while ticks keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_results >= 300)
        begin
            hold_done <= 1'b1;
            hold_left <= 150;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !take_break();
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_DEBOUNCE:   deb_limit = value[DEB_BITS-1:0];
            CFG_LONG_PRESS: long_limit = value;
            CFG_DOUBLE_TAP: tap_window = value;
            default:        ;
        endcase
    endtask

    task automatic set_timing(input logic [7:0] deb, input logic [15:0] long_ms,
                              input logic [15:0] tap_ms);
        write_reg(CFG_DEBOUNCE, {8'($urandom_range(255)), deb});
        write_reg(CFG_LONG_PRESS, long_ms);
        write_reg(CFG_DOUBLE_TAP, tap_ms);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_level(input bit level, input int unsigned n);
        repeat (n) pending_levels.push_back(level);
        n_queued += n;
    endtask

    task automatic queue_bits(input string pattern);
        for (int i = 0; i < pattern.len(); i++)
            queue_level(pattern[i] == "1", 1);
    endtask

    task automatic queue_random_ticks(input int unsigned n);
        int unsigned span;
        int unsigned run;
        int unsigned done;
        bit          level;
        done = 0;
        level = 1'b0;
        span = deb_limit + long_limit + tap_window + 4;
        while (done < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                level = !level;
                if (!level && $urandom_range(1))
                    run = $urandom_range(1, tap_window + 2);
                else
                    run = $urandom_range(1, span);
                queue_level(level, run);
            end
            else
            begin
                run = $urandom_range(1, 6);
                repeat (run) queue_level(1'($urandom_range(1)), 1);
            end
            done += run;
        end
    endtask

    task automatic wait_results_done();
        while (n_results != n_queued)
            @(posedge clk);
    endtask

    initial
    begin
        gest_state = ST_IDLE;
        elapsed = '0;
        deb_count = '0;
        long_done = 1'b0;
        led_rgb = COL_STANDBY;
        deb_limit = DEBOUNCE_RESET;
        long_limit = LONG_PRESS_RESET;
        tap_window = DOUBLE_TAP_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing, idle level only
        queue_bits("000");
        wait_results_done();

        // zero debounce and zero long press: immediate confirm, long press, double tap
        set_timing(8'd0, 16'd0, 16'd1);
        queue_bits("110000101000");
        queue_bits("1000");
        wait_results_done();

        // failed recheck, level ignored during the wait, failed second recheck
        set_timing(8'd2, 16'd5, 16'd4);
        queue_bits("100101101100000");
        wait_results_done();

        // widest debounce
        set_timing(8'd255, 16'd300, 16'd20);
        queue_level(1'b1, 320);
        queue_level(1'b0, 30);
        wait_results_done();

        write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
        @(negedge clk);
        cfg_we <= 1'b0;

        for (int p = 0; p < 10; p++)
        begin
            set_timing(($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(1, 6)),
                       16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)));
            queue_random_ticks(30);
            wait_results_done();
        end

        repeat (8) @(posedge clk);
        if (!failed && expected_ticks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
